[rtl/rgb2ycc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package rgb2ycc_pkg;

    localparam int MAX_HALF_WIDTH  = 1024;
    localparam int MAX_HALF_HEIGHT = 1024;

    // Counter and register widths follow the fixed field widths.
    localparam int DIM_W      = 11;
    localparam int LUMA_IDX_W = 22;
    localparam int CHR_IDX_W  = 20;

    // Register indexes on the configuration port.
    localparam logic [0:0] REG_HALF_WIDTH  = 1'b0;
    localparam logic [0:0] REG_HALF_HEIGHT = 1'b1;

    localparam logic [DIM_W-1:0] HALF_WIDTH_RESET  = 11'd320;
    localparam logic [DIM_W-1:0] HALF_HEIGHT_RESET = 11'd240;

    // Queue between the position tracker and the arithmetic pipeline.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } pixel_t;

    typedef struct packed {
        logic [7:0]            luma;
        logic [LUMA_IDX_W-1:0] luma_index;
        logic                  chroma_valid;
        logic [7:0]            cb;
        logic [7:0]            cr;
        logic [CHR_IDX_W-1:0]  chroma_index;
        logic                  frame_end;
    } result_t;

    // One classified pixel: its color, raster position and frame geometry.
    typedef struct packed {
        pixel_t           pix;
        logic [DIM_W-1:0] col;
        logic [DIM_W-1:0] row;
        logic [DIM_W-1:0] half_w;
        logic             chroma;
        logic             frame_end;
    } job_t;

endpackage

`default_nettype wire

[rtl/rgb2ycc_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module rgb2ycc_front (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [0:0]                     cfg_index,
    input  wire logic [rgb2ycc_pkg::DIM_W-1:0]  cfg_data,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire rgb2ycc_pkg::pixel_t            in_data,
    input  wire logic                           queue_full,
    output logic                                push,
    output rgb2ycc_pkg::job_t                   push_job
);

    localparam int DW = rgb2ycc_pkg::DIM_W;

    logic [DW-1:0] half_width_reg, half_width_next;
    logic [DW-1:0] half_height_reg, half_height_next;
    logic [DW-1:0] column_count_reg, column_count_next;
    logic [DW-1:0] row_count_reg, row_count_next;
    logic [DW-1:0] hw_eff, hh_eff;
    logic [DW:0]   width, height;
    logic [DW-1:0] col_cur, row_cur;
    logic          col_last, row_last;

    always_comb
    begin
        half_width_next  = half_width_reg;
        half_height_next = half_height_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                rgb2ycc_pkg::REG_HALF_WIDTH:  half_width_next  = cfg_data;
                rgb2ycc_pkg::REG_HALF_HEIGHT: half_height_next = cfg_data;
                default: ;
            endcase
        end
    end

    // Out-of-range sizes are pinned to the supported range.
    always_comb
    begin
        if (half_width_reg == '0)
            hw_eff = DW'(1);
        else if (half_width_reg > DW'(rgb2ycc_pkg::MAX_HALF_WIDTH))
            hw_eff = DW'(rgb2ycc_pkg::MAX_HALF_WIDTH);
        else
            hw_eff = half_width_reg;
        if (half_height_reg == '0)
            hh_eff = DW'(1);
        else if (half_height_reg > DW'(rgb2ycc_pkg::MAX_HALF_HEIGHT))
            hh_eff = DW'(rgb2ycc_pkg::MAX_HALF_HEIGHT);
        else
            hh_eff = half_height_reg;
    end

    assign width  = {hw_eff, 1'b0};
    assign height = {hh_eff, 1'b0};

    // A counter left beyond a shrunken frame restarts at zero.
    assign col_cur  = ({1'b0, column_count_reg} >= width) ? '0 : column_count_reg;
    assign row_cur  = ({1'b0, row_count_reg} >= height) ? '0 : row_count_reg;
    assign col_last = ({1'b0, col_cur} + (DW+1)'(1)) >= width;
    assign row_last = ({1'b0, row_cur} + (DW+1)'(1)) >= height;

    assign in_ready = !queue_full;
    assign push     = in_valid && in_ready;

    always_comb
    begin
        push_job.pix       = in_data;
        push_job.col       = col_cur;
        push_job.row       = row_cur;
        push_job.half_w    = hw_eff;
        push_job.chroma    = !col_cur[0] && !row_cur[0];
        push_job.frame_end = col_last && row_last;
    end

    always_comb
    begin
        column_count_next = column_count_reg;
        row_count_next    = row_count_reg;
        if (push)
        begin
            if (col_last)
            begin
                column_count_next = '0;
                row_count_next    = row_last ? '0 : row_cur + DW'(1);
            end
            else
            begin
                column_count_next = col_cur + DW'(1);
                row_count_next    = row_cur;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_width_reg   <= rgb2ycc_pkg::HALF_WIDTH_RESET;
            half_height_reg  <= rgb2ycc_pkg::HALF_HEIGHT_RESET;
            column_count_reg <= '0;
            row_count_reg    <= '0;
        end
        else
        begin
            half_width_reg   <= half_width_next;
            half_height_reg  <= half_height_next;
            column_count_reg <= column_count_next;
            row_count_reg    <= row_count_next;
        end
    end

endmodule

`default_nettype wire

[rtl/rgb2ycc_queue.sv]
`timescale 1ns / 1ps
`default_nettype none

module rgb2ycc_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire rgb2ycc_pkg::job_t push_job,
    input  wire logic              pop,
    output rgb2ycc_pkg::job_t      head_job,
    output logic                   full,
    output logic                   empty
);

    localparam int PW = rgb2ycc_pkg::QPTR_W;

    rgb2ycc_pkg::job_t mem [rgb2ycc_pkg::QUEUE_DEPTH];

    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PW:0]   count_reg, count_next;
    logic          do_push, do_pop;

    assign full     = count_reg == (PW+1)'(rgb2ycc_pkg::QUEUE_DEPTH);
    assign empty    = count_reg == '0;
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign head_job = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + PW'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + PW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + (PW+1)'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - (PW+1)'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

[rtl/rgb2ycc_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module rgb2ycc_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire rgb2ycc_pkg::job_t head_job,
    input  wire logic              queue_empty,
    output logic                   pop,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output rgb2ycc_pkg::result_t   out_data
);

    localparam int DW = rgb2ycc_pkg::DIM_W;
    localparam int LW = rgb2ycc_pkg::LUMA_IDX_W;
    localparam int CW = rgb2ycc_pkg::CHR_IDX_W;

    logic advance;

    logic signed [17:0] r_s, g_s, b_s;

    // Stage 1: weighted sums and index products.
    logic                  s1_valid_reg;
    logic signed [17:0]    y_sum_reg, cb_sum_reg, cr_sum_reg;
    logic [2*DW:0]         luma_prod_reg;
    logic [2*DW-2:0]       chroma_prod_reg;
    logic [DW-1:0]         s1_col_reg;
    logic                  s1_chroma_reg, s1_frame_end_reg;

    // Stage 2: shift, offset, clamp and index sums.
    logic                  out_valid_reg;
    rgb2ycc_pkg::result_t  out_data_reg, out_data_next;

    logic signed [17:0]    y_val, cb_val, cr_val;
    logic [2*DW+1:0]       luma_sum;
    logic [2*DW-1:0]       chroma_sum;

    // The whole pipeline moves together unless the output word is stuck.
    assign advance = !out_valid_reg || out_ready;
    assign pop     = advance && !queue_empty;

    assign r_s = $signed({10'd0, head_job.pix.red});
    assign g_s = $signed({10'd0, head_job.pix.green});
    assign b_s = $signed({10'd0, head_job.pix.blue});

    // Arithmetic right shift on a signed value floors toward minus infinity.
    assign y_val  = (y_sum_reg >>> 8) + 18'sd16;
    assign cb_val = (cb_sum_reg >>> 8) + 18'sd128;
    assign cr_val = (cr_sum_reg >>> 8) + 18'sd128;

    assign luma_sum   = {1'b0, luma_prod_reg} + (2*DW+2)'(s1_col_reg);
    assign chroma_sum = {1'b0, chroma_prod_reg} + (2*DW)'(s1_col_reg[DW-1:1]);

    always_comb
    begin
        out_data_next = '0;
        if (y_val < 18'sd16)
            out_data_next.luma = 8'd16;
        else if (y_val > 18'sd235)
            out_data_next.luma = 8'd235;
        else
            out_data_next.luma = y_val[7:0];
        out_data_next.luma_index   = luma_sum[LW-1:0];
        out_data_next.chroma_valid = s1_chroma_reg;
        out_data_next.frame_end    = s1_frame_end_reg;
        if (s1_chroma_reg)
        begin
            if (cb_val < 18'sd16)
                out_data_next.cb = 8'd16;
            else if (cb_val > 18'sd240)
                out_data_next.cb = 8'd240;
            else
                out_data_next.cb = cb_val[7:0];
            if (cr_val < 18'sd16)
                out_data_next.cr = 8'd16;
            else if (cr_val > 18'sd240)
                out_data_next.cr = 8'd240;
            else
                out_data_next.cr = cr_val[7:0];
            out_data_next.chroma_index = chroma_sum[CW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            y_sum_reg  <= 18'sd66 * r_s + 18'sd129 * g_s + 18'sd25 * b_s + 18'sd128;
            cb_sum_reg <= 18'sd112 * b_s - 18'sd38 * r_s - 18'sd74 * g_s + 18'sd128;
            cr_sum_reg <= 18'sd112 * r_s - 18'sd94 * g_s - 18'sd18 * b_s + 18'sd128;
            luma_prod_reg    <= (2*DW+1)'(head_job.row)
                                * (2*DW+1)'({head_job.half_w, 1'b0});
            chroma_prod_reg  <= (2*DW-1)'(head_job.row[DW-1:1])
                                * (2*DW-1)'(head_job.half_w);
            s1_col_reg       <= head_job.col;
            s1_chroma_reg    <= head_job.chroma;
            s1_frame_end_reg <= head_job.frame_end;
            out_data_reg     <= out_data_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg  <= !queue_empty;
            out_valid_reg <= s1_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

[rtl/rgb_to_ycbcr420_converter_unit.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel   Signals                                 Word
// input     in_valid, in_ready, in_data             one BGR pixel, raster order
// output    out_valid, out_ready, out_data          luma, chroma and plane indexes
// config    cfg_we, cfg_index, cfg_data             half_width (0), half_height (1)
//
// One pixel is taken per clock while in_ready is high; each result passes
// through the queue and then the two arithmetic stages before out_valid rises.
// Reset sets the frame to 640x480 and the raster position to the origin.
// A stalled output holds the whole arithmetic pipeline; the four-word queue
// keeps taking pixels until it fills, and then in_ready drops.

module rgb_to_ycbcr420_converter_unit (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire rgb2ycc_pkg::pixel_t           in_data,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output rgb2ycc_pkg::result_t               out_data,
    input  wire logic                          cfg_we,
    input  wire logic [0:0]                    cfg_index,
    input  wire logic [rgb2ycc_pkg::DIM_W-1:0] cfg_data
);

    rgb2ycc_pkg::job_t push_job;
    rgb2ycc_pkg::job_t head_job;
    logic              push, pop, queue_full, queue_empty;

    rgb2ycc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .queue_full (queue_full),
        .push       (push),
        .push_job   (push_job)
    );

    rgb2ycc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .full     (queue_full),
        .empty    (queue_empty)
    );

    rgb2ycc_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_job    (head_job),
        .queue_empty (queue_empty),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data)
    );

endmodule

`default_nettype wire

[rtl/rgb2ycc_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module rgb2ycc_checker (
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 out_valid,
    input wire logic                 out_ready,
    input wire rgb2ycc_pkg::result_t out_data
);

    // A word that is not taken stays put.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output word changed while stalled");

    a_luma_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.luma >= 8'd16 && out_data.luma <= 8'd235)
        else $error("luma out of range");

    // Pixels without chroma carry zeros in all chroma fields.
    a_chroma_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.chroma_valid |->
            out_data.cb == 8'd0 && out_data.cr == 8'd0 && out_data.chroma_index == '0)
        else $error("chroma fields set on a pixel without chroma");

    // Chroma sits on even columns of an even-width frame, so its luma index is even.
    a_chroma_even: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.chroma_valid |->
            !out_data.luma_index[0] && out_data.cb >= 8'd16 && out_data.cr >= 8'd16)
        else $error("chroma word at odd position or out of range");

endmodule

bind rgb_to_ycbcr420_converter_unit rgb2ycc_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

`default_nettype wire
